// ===== hw/rtl/hsc_pkg.sv =====
// Shared types and constants of the hashed summary cache.
// Request and result structs, controller command and status, entry layout.
// No dependencies.
`default_nettype none

package hsc_pkg;

  localparam int unsigned SLOTS       = 128;
  localparam int unsigned MAX_PLAYERS = 8;

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned LEN_W  = $clog2(MAX_PLAYERS + 1);
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned GEN_W  = 31;
  localparam int unsigned CNT_W  = 16;

  localparam logic [KEY_W-1:0] TEAM_MUL  = 32'd2654435761;
  localparam logic [KEY_W-1:0] DAY_MUL   = 32'd2246822519;
  localparam int unsigned      FOLD_SHIFT = 16;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_APPEND = 2'd2
  } hsc_kind_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [KEY_W-1:0] team_key;
    logic [KEY_W-1:0] day_key;
    logic [GEN_W-1:0] generation_tag;
    logic [KEY_W-1:0] candidate_key;
    logic [CNT_W-1:0] asian_count_in;
    logic [CNT_W-1:0] nonasian_count_in;
    logic             overflow_in;
    logic [KEY_W-1:0] player_key;
  } hsc_in_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] asian_count;
    logic [CNT_W-1:0] nonasian_count;
    logic             candidate_found;
  } hsc_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] team;
    logic [KEY_W-1:0] day;
    logic [GEN_W-1:0] generation;
    logic [CNT_W-1:0] asian;
    logic [CNT_W-1:0] nonasian;
  } hsc_hdr_t;

  typedef struct packed {
    logic             ovf;
    logic [LEN_W-1:0] len;
  } hsc_meta_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } hsc_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic out_busy;
  } hsc_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsc_ctrl.sv =====
// Controller of the hashed summary cache: sequences accept, execute, compare.
// Depends on hsc_pkg.
`default_nettype none

module hsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hsc_pkg::hsc_sts_t sts,
  output hsc_pkg::hsc_cmd_t cmd
);
  import hsc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd.load   = in_valid && !in_stall_r;
    cmd.exec   = (state_r == S_EXEC);
    cmd.finish = (state_r == S_CMP) && !sts.out_busy;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = sts.is_lookup ? S_CMP : S_IDLE;
      end
      S_CMP: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hsc_dpath.sv =====
// Datapath of the hashed summary cache: hash, entry stores, list lanes, compare.
// Depends on hsc_pkg and hsc_ram.
`default_nettype none

module hsc_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  hsc_pkg::hsc_cmd_t cmd,
  output hsc_pkg::hsc_sts_t sts,
  input  hsc_pkg::hsc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hsc_pkg::hsc_out_t out_item
);
  import hsc_pkg::*;

  hsc_in_t           item_r;
  logic [KEY_W-1:0]  team_prod;
  logic [KEY_W-1:0]  day_prod;
  logic [KEY_W-1:0]  team_prod_r;
  logic [KEY_W-1:0]  day_prod_r;
  logic [KEY_W-1:0]  mix;
  logic [KEY_W-1:0]  folded;
  logic [SLOT_W-1:0] slot;

  logic [SLOTS-1:0]  valid_r;
  logic              valid_q_r;
  logic              append_en_r;
  logic [SLOT_W-1:0] append_slot_r;
  logic [LEN_W-1:0]  cur_len_r;
  logic              cur_ovf_r;

  logic              do_lookup;
  logic              do_store;
  logic              do_append;
  logic              list_full;

  hsc_hdr_t          hdr_wdata;
  hsc_hdr_t          hdr_q;
  hsc_meta_t         meta_wdata;
  hsc_meta_t         meta_q;
  logic [SLOT_W-1:0] meta_waddr;

  logic [MAX_PLAYERS-1:0] lane_we;
  logic [KEY_W-1:0]       lane_q [MAX_PLAYERS];
  logic [MAX_PLAYERS-1:0] match;
  logic                   found;
  logic                   tag_hit;
  logic                   hit;
  hsc_out_t               out_nxt;
  hsc_out_t               out_item_r;
  logic                   out_valid_r;

  assign team_prod = in_item.team_key * TEAM_MUL;
  assign day_prod  = in_item.day_key * DAY_MUL;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r      <= in_item;
      team_prod_r <= team_prod;
      day_prod_r  <= day_prod;
    end
  end

  assign mix    = team_prod_r ^ day_prod_r;
  assign folded = mix ^ (mix >> FOLD_SHIFT);
  assign slot   = folded[SLOT_W-1:0];

  assign do_lookup = cmd.exec && (item_r.kind == KIND_LOOKUP);
  assign do_store  = cmd.exec && (item_r.kind == KIND_STORE) && (item_r.team_key != '0);
  assign do_append = cmd.exec && (item_r.kind == KIND_APPEND) && append_en_r;
  assign list_full = (cur_len_r == LEN_W'(MAX_PLAYERS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      append_en_r   <= 1'b0;
      append_slot_r <= '0;
      cur_len_r     <= '0;
      cur_ovf_r     <= 1'b0;
    end else begin
      if (do_store) begin
        valid_r[slot] <= 1'b1;
        append_en_r   <= 1'b1;
        append_slot_r <= slot;
        cur_len_r     <= '0;
        cur_ovf_r     <= item_r.overflow_in;
      end else if (do_append) begin
        if (list_full) begin
          cur_ovf_r <= 1'b1;
        end else begin
          cur_len_r <= cur_len_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      valid_q_r <= valid_r[slot];
    end
  end

  always_comb begin
    hdr_wdata.team       = item_r.team_key;
    hdr_wdata.day        = item_r.day_key;
    hdr_wdata.generation = item_r.generation_tag;
    hdr_wdata.asian      = item_r.asian_count_in;
    hdr_wdata.nonasian   = item_r.nonasian_count_in;
  end

  always_comb begin
    priority if (do_store) begin
      meta_wdata.ovf = item_r.overflow_in;
      meta_wdata.len = '0;
    end else if (list_full) begin
      meta_wdata.ovf = 1'b1;
      meta_wdata.len = cur_len_r;
    end else begin
      meta_wdata.ovf = cur_ovf_r;
      meta_wdata.len = cur_len_r + LEN_W'(1);
    end
  end

  assign meta_waddr = do_store ? slot : append_slot_r;

  hsc_ram #(
    .WIDTH ($bits(hsc_hdr_t)),
    .DEPTH (SLOTS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (slot),
    .wdata (hdr_wdata),
    .re    (do_lookup),
    .raddr (slot),
    .rdata (hdr_q)
  );

  hsc_ram #(
    .WIDTH ($bits(hsc_meta_t)),
    .DEPTH (SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (do_store || do_append),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (do_lookup),
    .raddr (slot),
    .rdata (meta_q)
  );

  for (genvar g = 0; g < MAX_PLAYERS; g++) begin : g_lane
    assign lane_we[g] = do_append && !list_full && (cur_len_r == LEN_W'(g));

    hsc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOTS)
    ) u_lane_ram (
      .clk   (clk),
      .we    (lane_we[g]),
      .waddr (append_slot_r),
      .wdata (item_r.player_key),
      .re    (do_lookup),
      .raddr (slot),
      .rdata (lane_q[g])
    );
  end

  always_comb begin
    for (int i = 0; i < MAX_PLAYERS; i++) begin
      match[i] = (LEN_W'(i) < meta_q.len) && (lane_q[i] == item_r.candidate_key);
    end
  end

  assign found   = (item_r.candidate_key != '0) && (|match);
  assign tag_hit = valid_q_r && (hdr_q.team == item_r.team_key) &&
                   (hdr_q.day == item_r.day_key) &&
                   (hdr_q.generation == item_r.generation_tag);
  assign hit     = tag_hit && !(meta_q.ovf && (item_r.candidate_key != '0) && !found);

  always_comb begin
    out_nxt.hit             = hit;
    out_nxt.asian_count     = hit ? hdr_q.asian : '0;
    out_nxt.nonasian_count  = hit ? hdr_q.nonasian : '0;
    out_nxt.candidate_found = hit && found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign sts.is_lookup = (item_r.kind == KIND_LOOKUP);
  assign sts.out_busy  = out_valid_r && out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_summary_cache_core.sv =====
// Hashed summary cache, top level: request and result channels, assertions.
// Depends on hsc_pkg, hsc_ctrl, hsc_dpath and hsc_ram.
//
// Usage:
//   Requests arrive on in_valid/in_stall/in_item: lookup, store entry header or
//   append player key. A request is taken when in_valid is high and in_stall
//   is low. Only a lookup produces a result, on out_valid/out_stall/out_item.
//   Timing: one request is worked on at a time. A store or append passes
//   through accept and execute; a lookup also through compare (hash multiply,
//   slot read from the header, list and length RAMs, then tag and list compare).
//   The result is registered into the output register as the compare state ends.
//   A held result does not block a new request; the compare waits only when
//   the output register is still full and stalled.
//   Reset: rst_n (synchronous, active low) clears all entry valid bits and the
//   append target at once; no clearing pass is needed.
//   Receiver stall: out_item holds until taken; in_stall stays high while the
//   pending lookup waits on the full output register.
`default_nettype none

module hashed_summary_cache_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hsc_pkg::hsc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output hsc_pkg::hsc_out_t out_item
);
  import hsc_pkg::*;

  hsc_cmd_t cmd;
  hsc_sts_t sts;

  hsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  a_accept_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without blocking the next one");

  a_finish_fills : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished lookup did not fill the output register");

  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result appeared without a finished lookup");
`endif

endmodule

`default_nettype wire
